### src/pds_pkg.sv
// shared types, widths and reset values for the pid differential steering block
`timescale 1ns / 1ps
`default_nettype none

package pds_pkg;

  // field widths
  localparam int ErrW     = 16;
  localparam int IntegW   = 24;
  localparam int DiffW    = ErrW + 1;
  localparam int GainW    = 16;
  localparam int SpeedW   = 8;
  localparam int CtrlW    = 16;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  // datapath widths
  localparam int ProdPW = GainW + ErrW;
  localparam int ProdIW = GainW + IntegW;
  localparam int ProdDW = GainW + DiffW;
  localparam int SumW   = ProdIW + 2;
  localparam int FracW  = 8;
  localparam int ShW    = SumW - FracW;
  localparam int SpdCalcW = CtrlW + 2;
  localparam int PivProdW = 2 * SpeedW;
  localparam int PivFracW = 4;

  // register indexes on the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    REG_GAIN_P          = 3'd0,
    REG_GAIN_I          = 3'd1,
    REG_GAIN_D          = 3'd2,
    REG_BASE_SPEED      = 3'd3,
    REG_PIVOT_THRESHOLD = 3'd4,
    REG_PIVOT_GAIN      = 3'd5
  } cfg_reg_e;

  // reset values of the configuration registers
  localparam logic signed [GainW-1:0] GainPRst  = 16'sd256;
  localparam logic signed [GainW-1:0] GainIRst  = 16'sd0;
  localparam logic signed [GainW-1:0] GainDRst  = 16'sd0;
  localparam logic [SpeedW-1:0]       BaseRst   = 8'd128;
  localparam logic [SpeedW-1:0]       ThreshRst = 8'd0;
  localparam logic [SpeedW-1:0]       PivGainRst = 8'd16;

  // configuration register set
  typedef struct packed {
    logic signed [GainW-1:0] gain_p;
    logic signed [GainW-1:0] gain_i;
    logic signed [GainW-1:0] gain_d;
    logic [SpeedW-1:0]       base_speed;
    logic [SpeedW-1:0]       pivot_threshold;
    logic [SpeedW-1:0]       pivot_gain;
  } cfg_t;

  // operands held in the input register
  typedef struct packed {
    logic signed [ErrW-1:0]   err;
    logic signed [IntegW-1:0] integ;
    logic signed [DiffW-1:0]  diff;
  } stage_t;

  // clamp a signed speed to the pwm range
  function automatic logic [SpeedW-1:0] clamp_u8(input logic signed [SpdCalcW-1:0] v);
    logic [SpeedW-1:0] r;
    if (v[SpdCalcW-1]) begin
      r = '0;
    end else if (|v[SpdCalcW-2:SpeedW]) begin
      r = '1;
    end else begin
      r = v[SpeedW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### src/pds_cfg_regs.sv
// configuration register file for the pid differential steering block
`timescale 1ns / 1ps
`default_nettype none

module pds_cfg_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [pds_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [pds_pkg::CfgDataW-1:0]    cfg_data_i,
  output pds_pkg::cfg_t                        cfg_o
);
  import pds_pkg::*;

  cfg_t cfg_q, cfg_d;

  // decode the register index, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_GAIN_P:          cfg_d.gain_p          = signed'(cfg_data_i[GainW-1:0]);
        REG_GAIN_I:          cfg_d.gain_i          = signed'(cfg_data_i[GainW-1:0]);
        REG_GAIN_D:          cfg_d.gain_d          = signed'(cfg_data_i[GainW-1:0]);
        REG_BASE_SPEED:      cfg_d.base_speed      = cfg_data_i[SpeedW-1:0];
        REG_PIVOT_THRESHOLD: cfg_d.pivot_threshold = cfg_data_i[SpeedW-1:0];
        REG_PIVOT_GAIN:      cfg_d.pivot_gain      = cfg_data_i[SpeedW-1:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  // register storage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p          <= GainPRst;
      cfg_q.gain_i          <= GainIRst;
      cfg_q.gain_d          <= GainDRst;
      cfg_q.base_speed      <= BaseRst;
      cfg_q.pivot_threshold <= ThreshRst;
      cfg_q.pivot_gain      <= PivGainRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### src/pds_front.sv
// input register with integral and previous error state
`timescale 1ns / 1ps
`default_nettype none

module pds_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [pds_pkg::ErrW-1:0] error_value_i,
  input  wire logic                          advance_i,
  output logic                               stage_valid_o,
  output pds_pkg::stage_t                    stage_o
);
  import pds_pkg::*;

  logic                     accept;
  logic                     stage_valid_q, stage_valid_d;
  stage_t                   stage_q;
  logic signed [IntegW-1:0] integral_q, integral_d;
  logic signed [ErrW-1:0]   last_error_q;
  logic signed [IntegW:0]   acc;
  logic signed [DiffW-1:0]  diff;

  // handshake: the stage frees up when the core takes its contents
  assign in_stall_o = stage_valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  // saturating integral and error difference
  always_comb begin
    acc  = (IntegW + 1)'(integral_q) + (IntegW + 1)'(error_value_i);
    diff = DiffW'(error_value_i) - DiffW'(last_error_q);
    if (acc[IntegW] != acc[IntegW-1]) begin
      integral_d = acc[IntegW] ? {1'b1, {(IntegW-1){1'b0}}} : {1'b0, {(IntegW-1){1'b1}}};
    end else begin
      integral_d = acc[IntegW-1:0];
    end
  end

  // stage occupancy
  always_comb begin
    if (accept) begin
      stage_valid_d = 1'b1;
    end else if (advance_i) begin
      stage_valid_d = 1'b0;
    end else begin
      stage_valid_d = stage_valid_q;
    end
  end

  // control state and feedback registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
      integral_q    <= '0;
      last_error_q  <= '0;
    end else begin
      stage_valid_q <= stage_valid_d;
      if (accept) begin
        integral_q   <= integral_d;
        last_error_q <= error_value_i;
      end
    end
  end

  // operand register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_q.err   <= error_value_i;
      stage_q.integ <= integral_d;
      stage_q.diff  <= diff;
    end
  end

  assign stage_valid_o = stage_valid_q;
  assign stage_o       = stage_q;

endmodule

`default_nettype wire

### src/pds_core.sv
// pid sum, speed clamps, pivot rule and result register
`timescale 1ns / 1ps
`default_nettype none

module pds_core (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             stage_valid_i,
  input  pds_pkg::stage_t                       stage_i,
  input  pds_pkg::cfg_t                         cfg_i,
  output logic                                  advance_o,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [pds_pkg::SpeedW-1:0]            left_speed_o,
  output logic [pds_pkg::SpeedW-1:0]            right_speed_o,
  output logic signed [pds_pkg::CtrlW-1:0]      control_value_o
);
  import pds_pkg::*;

  logic signed [ProdPW-1:0]   prod_p;
  logic signed [ProdIW-1:0]   prod_i;
  logic signed [ProdDW-1:0]   prod_d;
  logic signed [SumW-1:0]     sum;
  logic signed [ShW-1:0]      sh;
  logic                       cv_ovf;
  logic signed [CtrlW-1:0]    cv;
  logic signed [SpdCalcW-1:0] left_raw, right_raw;
  logic [SpeedW-1:0]          left_c, right_c;
  logic [PivProdW-1:0]        piv_prod;
  logic [PivProdW-PivFracW-1:0] piv_sh;
  logic [SpeedW-1:0]          pivot;
  logic [SpeedW-1:0]          left_d, right_d;

  logic                       out_valid_q;
  logic [SpeedW-1:0]          left_q, right_q;
  logic signed [CtrlW-1:0]    cv_q;

  // three gain products and their sum
  always_comb begin
    prod_p = ProdPW'(cfg_i.gain_p) * ProdPW'(stage_i.err);
    prod_i = ProdIW'(cfg_i.gain_i) * ProdIW'(stage_i.integ);
    prod_d = ProdDW'(cfg_i.gain_d) * ProdDW'(stage_i.diff);
    sum    = SumW'(prod_p) + SumW'(prod_i) + SumW'(prod_d);
  end

  // floor shift by the fraction bits, then saturate to the control width
  always_comb begin
    sh     = sum[SumW-1:FracW];
    cv_ovf = !((&sh[ShW-1:CtrlW-1]) || !(|sh[ShW-1:CtrlW-1]));
    if (cv_ovf) begin
      cv = sh[ShW-1] ? {1'b1, {(CtrlW-1){1'b0}}} : {1'b0, {(CtrlW-1){1'b1}}};
    end else begin
      cv = sh[CtrlW-1:0];
    end
  end

  // motor speeds around the base value
  always_comb begin
    left_raw  = signed'(SpdCalcW'(cfg_i.base_speed)) - SpdCalcW'(cv);
    right_raw = signed'(SpdCalcW'(cfg_i.base_speed)) + SpdCalcW'(cv);
    left_c    = clamp_u8(left_raw);
    right_c   = clamp_u8(right_raw);
  end

  // outer motor speed for a pivot turn
  always_comb begin
    piv_prod = PivProdW'(cfg_i.base_speed) * PivProdW'(cfg_i.pivot_gain);
    piv_sh   = piv_prod[PivProdW-1:PivFracW];
    pivot    = (|piv_sh[PivProdW-PivFracW-1:SpeedW]) ? '1 : piv_sh[SpeedW-1:0];
  end

  // pivot rule, left side checked first
  always_comb begin
    left_d  = left_c;
    right_d = right_c;
    if (left_c < cfg_i.pivot_threshold) begin
      right_d = pivot;
    end else if (right_c < cfg_i.pivot_threshold) begin
      left_d = pivot;
    end
  end

  // result register handshake
  assign advance_o = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance_o) begin
      out_valid_q <= stage_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && stage_valid_i) begin
      left_q  <= left_d;
      right_q <= right_d;
      cv_q    <= cv;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign left_speed_o    = left_q;
  assign right_speed_o   = right_q;
  assign control_value_o = cv_q;

endmodule

`default_nettype wire

### src/pid_differential_steer.sv
// top level of the pid differential steering block
// One signed line-position error per transaction gives one result transaction with the left
// and right motor pwm values and the saturated control value. The block takes one transaction
// every clock cycle while the result side is not stalled; an accepted transaction passes the
// input register, then the result register, before its result is presented. The integral
// and previous error are updated at acceptance, so the add-and-saturate loop on the integral
// allows one item per cycle. The user must write the configuration registers through the plain
// write port only while the block is idle; the block itself does not enforce this, and
// writes to indexes beyond the pivot gain register are ignored.
`timescale 1ns / 1ps
`default_nettype none

module pid_differential_steer (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [pds_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [pds_pkg::CfgDataW-1:0]     cfg_data_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic signed [pds_pkg::ErrW-1:0]  error_value_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [pds_pkg::SpeedW-1:0]            left_speed_o,
  output logic [pds_pkg::SpeedW-1:0]            right_speed_o,
  output logic signed [pds_pkg::CtrlW-1:0]      control_value_o
);
  import pds_pkg::*;

  cfg_t   cfg;
  stage_t stage;
  logic   stage_valid;
  logic   advance;

  // configuration registers
  pds_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // input register and controller state
  pds_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .error_value_i (error_value_i),
    .advance_i     (advance),
    .stage_valid_o (stage_valid),
    .stage_o       (stage)
  );

  // arithmetic and result register
  pds_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .stage_valid_i   (stage_valid),
    .stage_i         (stage),
    .cfg_i           (cfg),
    .advance_o       (advance),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .left_speed_o    (left_speed_o),
    .right_speed_o   (right_speed_o),
    .control_value_o (control_value_o)
  );

`ifndef SYNTHESIS
  // input side only stalls while the input register holds a transaction
  a_stall_needs_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> stage_valid)
    else $error("input stalled with an empty input register");

  // an accepted transaction lands in the input register
  a_accept_fills_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> stage_valid)
    else $error("accepted transaction missing from input register");

  // a transaction moved on from the input register shows up as a result
  a_stage_to_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_valid && advance) |=> out_valid_o)
    else $error("transaction lost between input and result registers");
`endif

endmodule

`default_nettype wire

### dv/testbench.sv
// self-checking testbench for the pid differential steering block
`timescale 1ns / 1ps

module testbench;
  import pds_pkg::*;

  typedef logic signed [ErrW-1:0]  err_t;
  typedef logic signed [GainW-1:0] gain_t;
  typedef logic [SpeedW-1:0]       speed_t;

  typedef struct packed {
    speed_t                  left_pwm;
    speed_t                  right_pwm;
    logic signed [CtrlW-1:0] ctrl;
  } steer_out_t;

  // indexes outside the register map, writes there must be ignored
  localparam logic [CfgIdxW-1:0] RegUnmappedA = 3'd6;
  localparam logic [CfgIdxW-1:0] RegUnmappedB = 3'd7;

  localparam int IntegMax   = 2 ** (IntegW - 1) - 1;
  localparam int IntegMin   = -(2 ** (IntegW - 1));
  localparam int CtrlMax    = 2 ** (CtrlW - 1) - 1;
  localparam int CtrlMin    = -(2 ** (CtrlW - 1));
  localparam int PwmMax     = 2 ** SpeedW - 1;
  localparam int CycleLimit = 200000;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   cfg_we_i = 1'b0;
  logic   [CfgIdxW-1:0] cfg_idx_i = '0;
  logic   [CfgDataW-1:0] cfg_data_i = '0;
  logic   in_valid_i = 1'b0;
  logic   in_stall_o;
  err_t   error_value_i = '0;
  logic   out_valid_o;
  logic   out_stall_i = 1'b0;
  speed_t left_speed_o;
  speed_t right_speed_o;
  logic signed [CtrlW-1:0] control_value_o;

  // predictor copy of the registers and the loop state
  gain_t  k_p = GainPRst;
  gain_t  k_i = GainIRst;
  gain_t  k_d = GainDRst;
  speed_t base_spd = BaseRst;
  speed_t pivot_thr = ThreshRst;
  speed_t pivot_mul = PivGainRst;
  logic signed [IntegW-1:0] integ_acc = '0;
  err_t   prev_err = '0;

  err_t       err_pending_q[$];
  steer_out_t steer_expect_q[$];
  steer_out_t seen_exp;
  int         issued_cnt = 0;
  int         accepted_cnt = 0;
  int         fail_cnt = 0;
  int         cycle_cnt = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  logic       in_taken = 1'b0;

  pid_differential_steer u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .error_value_i   (error_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .left_speed_o    (left_speed_o),
    .right_speed_o   (right_speed_o),
    .control_value_o (control_value_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic speed_t clamp_pwm(input int v);
    if (v < 0) return '0;
    if (v > PwmMax) return '1;
    return speed_t'(v);
  endfunction

  // steering law: integral update, pid sum, clamps and pivot rule
  function automatic steer_out_t predict_steer(input err_t err);
    logic signed [IntegW:0]   acc;
    logic signed [DiffW-1:0]  diff;
    logic signed [SumW-1:0]   sum;
    logic signed [SumW-1:0]   shifted;
    logic signed [CtrlW-1:0]  cv;
    int base_v, cv_v, lft, rgt, piv;
    steer_out_t res;
    acc = (IntegW + 1)'(integ_acc) + (IntegW + 1)'(err);
    if (acc > IntegMax) acc = (IntegW + 1)'(IntegMax);
    if (acc < IntegMin) acc = (IntegW + 1)'(IntegMin);
    integ_acc = acc[IntegW-1:0];
    diff = DiffW'(err) - DiffW'(prev_err);
    prev_err = err;
    sum = SumW'(k_p) * SumW'(err) + SumW'(k_i) * SumW'(integ_acc)
        + SumW'(k_d) * SumW'(diff);
    // arithmetic shift floors negative sums
    shifted = sum >>> FracW;
    if (shifted > CtrlMax) cv = CtrlW'(CtrlMax);
    else if (shifted < CtrlMin) cv = CtrlW'(CtrlMin);
    else cv = shifted[CtrlW-1:0];
    base_v = int'(base_spd);
    cv_v = int'(cv);
    lft = int'(clamp_pwm(base_v - cv_v));
    rgt = int'(clamp_pwm(base_v + cv_v));
    piv = (base_v * int'(pivot_mul)) >> PivFracW;
    if (piv > PwmMax) piv = PwmMax;
    // left side has priority when both fall under the threshold
    if (lft < int'(pivot_thr)) rgt = piv;
    else if (rgt < int'(pivot_thr)) lft = piv;
    res.left_pwm = speed_t'(lft);
    res.right_pwm = speed_t'(rgt);
    res.ctrl = cv;
    return res;
  endfunction

  function automatic gain_t rand_gain();
    gain_t g;
    case ($urandom_range(3))
      0: begin
        case ($urandom_range(3))
          0: g = 16'sh8000;
          1: g = 16'sh7fff;
          2: g = '0;
          default: g = 16'sd256;
        endcase
      end
      1: g = gain_t'(int'($urandom_range(2048)) - 1024);
      default: g = gain_t'($urandom);
    endcase
    return g;
  endfunction

  function automatic speed_t rand_byte();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return speed_t'($urandom);
    endcase
  endfunction

  function automatic err_t rand_error();
    int pick;
    pick = $urandom_range(9);
    if (pick < 3) return err_t'(int'($urandom_range(800)) - 400);
    if (pick == 3) begin
      case ($urandom_range(3))
        0: return 16'sh7fff;
        1: return 16'sh8000;
        2: return '0;
        default: return -16'sd1;
      endcase
    end
    return err_t'($urandom);
  endfunction

  task automatic issue_item(input err_t err);
    err_pending_q.push_back(err);
    issued_cnt++;
  endtask

  // block until every issued transaction has come back
  task automatic wait_idle();
    do @(negedge clk_i);
    while (accepted_cnt != issued_cnt || steer_expect_q.size() != 0);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_GAIN_P:          k_p = data;
      REG_GAIN_I:          k_i = data;
      REG_GAIN_D:          k_d = data;
      REG_BASE_SPEED:      base_spd = data[SpeedW-1:0];
      REG_PIVOT_THRESHOLD: pivot_thr = data[SpeedW-1:0];
      REG_PIVOT_GAIN:      pivot_mul = data[SpeedW-1:0];
      default: ;
    endcase
  endtask

  // full register set; upper bits of byte registers carry noise
  task automatic set_steering(input gain_t gp, input gain_t gi, input gain_t gd,
                              input speed_t base, input speed_t thr, input speed_t mul);
    write_reg(REG_GAIN_P, gp);
    write_reg(REG_GAIN_I, gi);
    write_reg(REG_GAIN_D, gd);
    write_reg(REG_BASE_SPEED, {8'($urandom), base});
    write_reg(REG_PIVOT_THRESHOLD, {8'($urandom), thr});
    write_reg(REG_PIVOT_GAIN, {8'($urandom), mul});
    write_reg(RegUnmappedA, 16'($urandom));
    write_reg(RegUnmappedB, 16'($urandom));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // input driver: offers queued errors, holds each until taken
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (err_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        error_value_i <= err_pending_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // monitor: check result transactions, then predict accepted inputs
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (steer_expect_q.size() == 0) begin
          $error("result with nothing expected: left %0d right %0d control %0d",
                 left_speed_o, right_speed_o, control_value_o);
          fail_cnt++;
        end else begin
          seen_exp = steer_expect_q.pop_front();
          if (left_speed_o !== seen_exp.left_pwm) begin
            $error("left_speed: expected %0d, actual %0d", seen_exp.left_pwm, left_speed_o);
            fail_cnt++;
          end
          if (right_speed_o !== seen_exp.right_pwm) begin
            $error("right_speed: expected %0d, actual %0d", seen_exp.right_pwm, right_speed_o);
            fail_cnt++;
          end
          if (control_value_o !== seen_exp.ctrl) begin
            $error("control_value: expected %0d, actual %0d", seen_exp.ctrl, control_value_o);
            fail_cnt++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        steer_expect_q.push_back(predict_steer(error_value_i));
        accepted_cnt++;
      end
    end
    in_taken <= in_valid_i && !in_stall_o;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    int mag;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 8;
    recv_idle_pct = 75;

    // reset settings: unity proportional gain, every error bit toggled
    issue_item(16'sd0);
    issue_item(16'sd1);
    issue_item(-16'sd1);
    issue_item(16'sh7fff);
    issue_item(16'sh8000);
    issue_item(16'sh5555);
    issue_item(16'shaaaa);
    issue_item(16'sd200);
    issue_item(-16'sd200);
    wait_idle();

    // tiny proportional and integral gains, maximum derivative gain, pivot speed saturates
    set_steering(16'sd1, -16'sd1, 16'sh7fff, 8'd255, 8'd255, 8'd255);
    issue_item(-16'sd1);
    issue_item(16'sd3);
    issue_item(16'sh8000);
    issue_item(16'sh7fff);
    issue_item(16'sd0);
    wait_idle();

    // extreme gains saturate the control value, zero base and pivot
    set_steering(16'sh8000, 16'sh7fff, 16'sh8000, 8'd0, 8'd0, 8'd0);
    issue_item(16'sh7fff);
    issue_item(16'sh8000);
    issue_item(16'sd100);
    issue_item(-16'sd5);
    wait_idle();

    // pivot rule on each side, and both sides under threshold
    set_steering(16'sd128, 16'sd0, 16'sd0, 8'd40, 8'd60, 8'd24);
    issue_item(16'sd0);
    issue_item(16'sd120);
    issue_item(-16'sd120);
    issue_item(16'sh7fff);
    wait_idle();

    // random phases; pushes drive the integral into both rails
    for (int ph = 0; ph < 12; ph++) begin
      if (ph < 4) begin
        send_idle_pct = 8;
        recv_idle_pct = 75;
      end else if (ph < 8) begin
        send_idle_pct = 75;
        recv_idle_pct = 8;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_steering(rand_gain(), rand_gain(), rand_gain(), rand_byte(), rand_byte(),
                   rand_byte());
      if (ph % 4 == 2) begin
        for (int n = 0; n < 280; n++) begin
          mag = $urandom_range(32767, 31000);
          issue_item((ph == 2) ? err_t'(mag) : err_t'(-mag - 1));
        end
        for (int n = 0; n < 20; n++) issue_item(rand_error());
      end else begin
        for (int n = 0; n < 50; n++) issue_item(rand_error());
      end
      wait_idle();
    end

    // allow for the pipeline to flush any stray result
    repeat (4) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### pid_differential_steer.f
src/pds_pkg.sv
src/pds_cfg_regs.sv
src/pds_front.sv
src/pds_core.sv
src/pid_differential_steer.sv
dv/testbench.sv
